>>> sv/open_addressing_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the open-addressing hash table
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define OAHT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold at every clock edge where ante holds
`define OAHT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Types, codes and defaults shared by the hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

  // parameter defaults
  localparam int CAPACITY_LOG2_DEF = 6;
  localparam int KEY_BITS_DEF      = 32;
  localparam int VALUE_BITS_DEF    = 32;

  // payload field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int KIND_W   = 2;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_LSB = 2;
  localparam logic [PADDR_W-REG_LSB-1:0] REG_PROBE_KIND = '0;

  // double hashing stride is ((key >> DBL_SHIFT) + DBL_BIAS) mod (capacity - 1)
  localparam int DBL_SHIFT = 5;
  localparam int DBL_BIAS  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADKEY = 2'd3
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINEAR = 2'd0,
    KIND_QUAD   = 2'd1,
    KIND_DOUBLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_W-1:0]   slot;
  } rsp_t;

  // controller -> probe sequencer
  typedef struct packed {
    logic start;
    logic advance;
  } probe_ctl_t;

  // probe sequencer -> controller
  typedef struct packed {
    logic ready;
    logic last;
  } probe_sts_t;

endpackage

>>> sv/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/oaht_probe.sv
// ----------------------------------------------------------------------------
// oaht_probe
// Probe address sequencer: home slot, linear, alternating quadratic and
// double hashing sequences, one address per advance.
// ----------------------------------------------------------------------------
module oaht_probe #(
  parameter int CAPACITY_LOG2 = oaht_pkg::CAPACITY_LOG2_DEF,
  parameter int KEY_BITS      = oaht_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  oaht_pkg::probe_ctl_t        ctl,
  input  logic [oaht_pkg::KIND_W-1:0] kind,
  input  logic [KEY_BITS-1:0]         key,
  output oaht_pkg::probe_sts_t        sts,
  output logic [CAPACITY_LOG2-1:0]    addr
);
  import oaht_pkg::*;

  localparam int AW   = CAPACITY_LOG2;
  localparam int FW   = KEY_BITS - DBL_SHIFT + 1;
  localparam int FWP  = (FW > AW) ? FW : AW;
  localparam int MODV = (1 << AW) - 1;
  localparam logic [AW:0] MOD = MODV[AW:0];

  logic [AW-1:0]  home;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  k;
  logic [AW-1:0]  sq;
  logic [AW-1:0]  step;
  logic [AW-1:0]  stride;
  logic [FWP-1:0] fold_src;
  logic           fold_busy;

  logic [AW:0] fold_sum;
  logic [AW:0] fold_mod;
  logic [AW:0] step_sum;
  logic [AW:0] step_mod;

  // the stride is reduced mod 2^AW-1 by summing AW-bit digits of the source
  assign fold_sum = {1'b0, stride} + {1'b0, fold_src[AW-1:0]};
  assign fold_mod = (fold_sum >= MOD) ? fold_sum - MOD : fold_sum;
  assign step_sum = {1'b0, step} + {1'b0, stride};
  assign step_mod = (step_sum >= MOD) ? step_sum - MOD : step_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_busy <= 1'b0;
    end else if (ctl.start) begin
      fold_busy <= (kind == KIND_DOUBLE);
    end else if (fold_busy && (fold_src == '0)) begin
      fold_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      home     <= AW'(key);
      idx      <= '0;
      k        <= '0;
      sq       <= '0;
      step     <= '0;
      stride   <= '0;
      fold_src <= FWP'(key >> DBL_SHIFT) + FWP'(DBL_BIAS);
    end else if (fold_busy) begin
      if (fold_src != '0) begin
        stride   <= fold_mod[AW-1:0];
        fold_src <= fold_src >> AW;
      end
    end else if (ctl.advance) begin
      idx  <= idx + 1'b1;
      step <= step_mod[AW-1:0];
      // k steps up on the way to every odd probe number
      if (!idx[0]) begin
        k  <= k + 1'b1;
        sq <= sq + {k[AW-2:0], 1'b1};
      end
    end
  end

  always_comb begin
    case (kind)
      KIND_QUAD:   addr = idx[0] ? home + sq : home - sq;
      KIND_DOUBLE: addr = home + step;
      default:     addr = home + idx;
    endcase
  end

  assign sts.ready = !fold_busy;
  assign sts.last  = (idx == '1);

endmodule

>>> sv/open_addressing_hash_table.sv
// Probing: a request reads P slots, P = probes made (1 to capacity);
//   a zero key or unused mode is answered without probing. Double hashing
//   first folds the stride before its first probe.
// Requests: a new request is taken only once the last result is registered;
//   the key RAM read port takes one probe per cycle once the stride fold is done.
// Reset: clears probe_kind, slot valid bits and live count; no clearing pass.
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Key/value table with open addressing and tombstones, kept in slot RAMs.
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_assert.svh"

module open_addressing_hash_table #(
  parameter int CAPACITY_LOG2 = oaht_pkg::CAPACITY_LOG2_DEF,
  parameter int KEY_BITS      = oaht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS    = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  oaht_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output oaht_pkg::rsp_t               rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [oaht_pkg::PADDR_W-1:0] paddr,
  input  logic [oaht_pkg::PDATA_W-1:0] pwdata,
  output logic [oaht_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import oaht_pkg::*;

  localparam int AW       = CAPACITY_LOG2;
  localparam int CAP      = 1 << AW;
  localparam int LW       = AW + 1;
  localparam int KEY_USE  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VAL_USE  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int SLOT_USE = (AW < SLOT_W) ? AW : SLOT_W;

  // ---------------- configuration ----------------
  logic [KIND_W-1:0]            probe_kind;
  logic [PADDR_W-REG_LSB-1:0]   reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:REG_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_PROBE_KIND) ? PDATA_W'(probe_kind) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_kind <= KIND_LINEAR;
    end else if (cfg_wr && (reg_idx == REG_PROBE_KIND)) begin
      probe_kind <= pwdata[KIND_W-1:0];
    end
  end

  // ---------------- request capture ----------------
  fsm_state_t state;
  fsm_state_t state_next;

  logic                  accept;
  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic                  early_in;

  logic [MODE_W-1:0]     cur_mode;
  logic [KEY_BITS-1:0]   cur_key;
  logic [VALUE_BITS-1:0] cur_val;
  logic                  early;
  logic [STATUS_W-1:0]   early_status;

  assign accept   = req_valid && !req_stall;
  assign key_in   = KEY_BITS'(req.key[KEY_USE-1:0]);
  assign val_in   = VALUE_BITS'(req.value[VAL_USE-1:0]);
  assign early_in = (key_in == '0) || !((req.mode == MODE_FIND) ||
                    (req.mode == MODE_INSERT) || (req.mode == MODE_REMOVE));

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode     <= req.mode;
      cur_key      <= key_in;
      cur_val      <= val_in;
      early        <= early_in;
      early_status <= (key_in == '0) ? STAT_BADKEY : STAT_MISS;
    end
  end

  // ---------------- probe sequencer ----------------
  probe_ctl_t    gen_ctl;
  probe_sts_t    gen_sts;
  logic [AW-1:0] gen_addr;
  logic          issue;

  assign gen_ctl.start   = accept && !early_in;
  assign gen_ctl.advance = issue;

  oaht_probe #(
    .CAPACITY_LOG2 (CAPACITY_LOG2),
    .KEY_BITS      (KEY_BITS)
  ) u_probe (
    .clk  (clk),
    .rst  (rst),
    .ctl  (gen_ctl),
    .kind (probe_kind),
    .key  (key_in),
    .sts  (gen_sts),
    .addr (gen_addr)
  );

  // ---------------- slot memories ----------------
  logic                  kram_we;
  logic [AW-1:0]         slot_sel;
  logic [KEY_BITS:0]     kram_wdata;
  logic [KEY_BITS:0]     kram_rdata;
  logic                  vram_we;
  logic [VALUE_BITS-1:0] vram_rdata;
  logic [CAP-1:0]        slot_valid;

  // key RAM entry: {tombstone, key}
  oaht_ram #(
    .WIDTH (KEY_BITS + 1),
    .DEPTH (CAP)
  ) u_key_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (slot_sel),
    .wdata (kram_wdata),
    .re    (issue),
    .raddr (gen_addr),
    .rdata (kram_rdata)
  );

  oaht_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAP)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (slot_sel),
    .wdata (cur_val),
    .re    (issue),
    .raddr (gen_addr),
    .rdata (vram_rdata)
  );

  // a slot never written reads as an empty key with no tombstone
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (kram_we) begin
      slot_valid[slot_sel] <= 1'b1;
    end
  end

  // ---------------- probe check stage ----------------
  logic                  chk_vld;
  logic                  chk_last;
  logic [AW-1:0]         chk_addr;
  logic                  chk_valid_bit;
  logic [KEY_BITS-1:0]   rd_key;
  logic                  rd_tomb;
  logic                  rd_empty;
  logic                  rd_match;
  logic                  stop_now;
  logic                  issued_all;

  logic                  hit;
  logic                  have_free;
  logic [AW-1:0]         hit_slot;
  logic [AW-1:0]         free_slot;
  logic [VALUE_BITS-1:0] hit_val;

  assign rd_key   = chk_valid_bit ? kram_rdata[KEY_BITS-1:0] : '0;
  assign rd_tomb  = chk_valid_bit && kram_rdata[KEY_BITS];
  assign rd_empty = (rd_key == '0);
  assign rd_match = !rd_tomb && (rd_key == cur_key);
  assign stop_now = chk_vld && (rd_empty || rd_match || chk_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_addr      <= gen_addr;
      chk_last      <= gen_sts.last;
      chk_valid_bit <= slot_valid[gen_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued_all <= 1'b0;
      hit        <= 1'b0;
      have_free  <= 1'b0;
    end else if (accept) begin
      issued_all <= 1'b0;
      hit        <= 1'b0;
      have_free  <= 1'b0;
    end else begin
      if (issue && gen_sts.last) begin
        issued_all <= 1'b1;
      end
      if (chk_vld) begin
        // remember the first empty or tombstone slot passed
        if (!have_free && (rd_empty || rd_tomb)) begin
          have_free <= 1'b1;
        end
        if (!rd_empty && rd_match) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_vld && !have_free && (rd_empty || rd_tomb)) begin
      free_slot <= chk_addr;
    end
    if (chk_vld && !rd_empty && rd_match) begin
      hit_slot <= chk_addr;
      hit_val  <= vram_rdata;
    end
  end

  // ---------------- control ----------------
  logic fin_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = early_in ? S_FINISH : S_PROBE;
        end
      end
      S_PROBE: begin
        if (stop_now) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    issue     = 1'b0;
    fin_go    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_PROBE: begin
        issue = gen_sts.ready && !issued_all && !stop_now;
      end
      S_FINISH: begin
        // hold until the result register can take the transfer
        fin_go = !rsp_valid || !rsp_stall;
      end
      default: ;
    endcase
  end

  // ---------------- commit and result ----------------
  logic                do_find;
  logic                do_ins;
  logic                do_rem;
  logic                success;
  logic                ins_new;
  logic [STATUS_W-1:0] status_sel;
  logic [LW-1:0]       live_count;

  assign do_find  = !early && (cur_mode == MODE_FIND);
  assign do_ins   = !early && (cur_mode == MODE_INSERT);
  assign do_rem   = !early && (cur_mode == MODE_REMOVE);
  assign ins_new  = do_ins && !hit && have_free;
  assign success  = hit ? (do_find || do_ins || do_rem) : ins_new;
  assign slot_sel = hit ? hit_slot : free_slot;

  assign kram_we    = fin_go && (ins_new || (do_rem && hit));
  assign kram_wdata = {do_rem, cur_key};
  assign vram_we    = fin_go && do_ins && (hit || have_free);

  always_comb begin
    if (early) begin
      status_sel = early_status;
    end else if (success) begin
      status_sel = STAT_DONE;
    end else if (do_ins) begin
      status_sel = STAT_FULL;
    end else begin
      status_sel = STAT_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (fin_go) begin
      if (ins_new) begin
        live_count <= live_count + 1'b1;
      end else if (do_rem && hit && (live_count != '0)) begin
        live_count <= live_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp.status    <= status_sel;
      rsp.value_out <= (do_find && hit) ? VALUE_W'(hit_val[VAL_USE-1:0]) : '0;
      rsp.slot      <= success ? SLOT_W'(slot_sel[SLOT_USE-1:0]) : '0;
    end
  end

  // ---------------- assertions ----------------
  `OAHT_ASSERT_ALWAYS(a_live_bound, live_count <= LW'(CAP), "live count above capacity")
  `OAHT_ASSERT_IMPLY(a_key_nonzero, kram_we, kram_wdata[KEY_BITS-1:0] != '0, "zero key written")
  `OAHT_ASSERT_IMPLY(a_no_extra_probe, issued_all, !issue, "probe issued past capacity")
  `OAHT_ASSERT_IMPLY(a_finish_clean, state == S_FINISH, !chk_vld, "read in flight at finish")

endmodule

>>> tb/oaht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oaht_checker
// Keeps a shadow copy of the slot table, predicts the result of every
// request transfer and compares each result transfer against it in order.
// ----------------------------------------------------------------------------
module oaht_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_stall,
  input  oaht_pkg::req_t               req,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  oaht_pkg::rsp_t               rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [oaht_pkg::PADDR_W-1:0] paddr,
  input  logic [oaht_pkg::PDATA_W-1:0] pwdata,
  input  logic                         done,
  output int                           fail_count
);
  import oaht_pkg::*;

  localparam int SLOTS     = 1 << CAPACITY_LOG2_DEF;
  localparam int MAX_SHOWN = 10;

  logic [KEY_W-1:0]   slot_key  [SLOTS];
  logic [VALUE_W-1:0] slot_val  [SLOTS];
  logic               slot_tomb [SLOTS];
  logic [KIND_W-1:0]  probe_kind;
  rsp_t               expected_rsp[$];
  int                 errors = 0;
  int                 missing = 0;

  assign fail_count = errors + missing;

  function automatic logic [SLOT_W-1:0] probe_slot(logic [KEY_W-1:0] key, int i);
    logic [63:0] home;
    logic [63:0] k;
    logic [63:0] stride;
    logic [63:0] idx;
    home = 64'(key[SLOT_W-1:0]);
    case (probe_kind)
      KIND_QUAD: begin
        // offsets count from home: +1, -1, +4, -4, +9, ...
        k = (64'(i) + 1) / 2;
        idx = i[0] ? home + k * k : home - k * k;
      end
      KIND_DOUBLE: begin
        stride = ((64'(key) >> DBL_SHIFT) + 64'(DBL_BIAS)) % 64'(SLOTS - 1);
        idx = home + ((64'(i) % 64'(SLOTS - 1)) * stride) % 64'(SLOTS - 1);
      end
      default: idx = home + 64'(i);
    endcase
    return idx[SLOT_W-1:0];
  endfunction

  // Walk the probe sequence, apply the request to the shadow table.
  function automatic rsp_t apply_request(req_t r);
    rsp_t              o;
    logic              hit;
    logic              have_free;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] hit_at;
    logic [SLOT_W-1:0] free_at;
    o.status = STAT_MISS;
    o.value_out = '0;
    o.slot = '0;
    hit = 1'b0;
    have_free = 1'b0;
    hit_at = '0;
    free_at = '0;
    if (r.key == '0) begin
      o.status = STAT_BADKEY;
      return o;
    end
    if (r.mode != MODE_FIND && r.mode != MODE_INSERT && r.mode != MODE_REMOVE) return o;
    for (int i = 0; i < SLOTS; i++) begin
      s = probe_slot(r.key, i);
      if (slot_key[s] == '0) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_at = s;
        end
        break;
      end
      if (slot_tomb[s]) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_at = s;
        end
        continue;
      end
      if (slot_key[s] == r.key) begin
        hit = 1'b1;
        hit_at = s;
        break;
      end
    end
    case (r.mode)
      MODE_FIND: begin
        if (hit) begin
          o.status = STAT_DONE;
          o.value_out = slot_val[hit_at];
          o.slot = hit_at;
        end
      end
      MODE_INSERT: begin
        if (hit) begin
          slot_val[hit_at] = r.value;
          o.status = STAT_DONE;
          o.slot = hit_at;
        end else if (have_free) begin
          slot_key[free_at] = r.key;
          slot_val[free_at] = r.value;
          slot_tomb[free_at] = 1'b0;
          o.status = STAT_DONE;
          o.slot = free_at;
        end else begin
          o.status = STAT_FULL;
        end
      end
      default: begin
        if (hit) begin
          slot_tomb[hit_at] = 1'b1;
          o.status = STAT_DONE;
          o.slot = hit_at;
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_key[s] = '0;
        slot_val[s] = '0;
        slot_tomb[s] = 1'b0;
      end
      probe_kind = KIND_LINEAR;
      expected_rsp.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:REG_LSB] == REG_PROBE_KIND)
        probe_kind = pwdata[KIND_W-1:0];
      // results first: a result never belongs to a request taken in the same cycle
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: result with nothing expected: status %0d value %h slot %0d",
                     $realtime, rsp.status, rsp.value_out, rsp.slot);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
              rsp.slot !== want.slot) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display({"%0t: mismatch: expected status %0d value %h slot %0d, ",
                        "got status %0d value %h slot %0d"},
                       $realtime, want.status, want.value_out, want.slot,
                       rsp.status, rsp.value_out, rsp.slot);
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(apply_request(req));
    end
  end

  always @(posedge done) begin
    missing = expected_rsp.size();
    if (missing != 0 && errors < MAX_SHOWN)
      $display("%0t: %0d expected results never arrived", $realtime, missing);
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives find, insert, remove and unused-mode requests into the hash table under each
// probe kind, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module tb;
  import oaht_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_PROBE_KIND = {REG_PROBE_KIND, {REG_LSB{1'b0}}};
  localparam int POOL_SIZE    = 96;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 305;
  localparam int DRAIN_CYCLES = 100;
  localparam int KEY_HI_W     = KEY_W - SLOT_W;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               done;
  int                 fail_count;
  int                 sent = 0;
  int                 received = 0;
  int                 burst_left = 0;
  int                 stall_style = 0;
  int                 stall_span = 0;
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  logic [SLOT_W-1:0]  hot_home [4];
  logic [KIND_W-1:0]  phase_kind [PHASES];
  mix_t               phase_mix [PHASES];

  open_addressing_hash_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  oaht_checker table_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .done       (done),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) received <= received + 1;
  end

  // switch between no stall, light stall and heavy stall every stretch
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_span <= $urandom_range(16, 128);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 2) == 0);
      default: rsp_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic send(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                      logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= '{mode: mode, key: key, value: value};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (received != sent) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(mix_t mix);
    int r;
    int insert_lim;
    int find_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        insert_lim = 72;
        find_lim = 87;
      end
      MIX_BALANCED: begin
        insert_lim = 40;
        find_lim = 75;
      end
      default: begin
        insert_lim = 15;
        find_lim = 40;
      end
    endcase
    if (r < 2) return MODE_UNUSED;
    if (r < insert_lim) return MODE_INSERT;
    if (r < find_lim) return MODE_FIND;
    return MODE_REMOVE;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 10) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    logic [SLOT_W-1:0] home;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    done <= 1'b0;

    // half the pool piles onto a few home slots to force long probe chains
    foreach (hot_home[j]) hot_home[j] = SLOT_W'($urandom_range(0, 63));
    foreach (key_pool[j]) begin
      home = $urandom_range(0, 1) ? hot_home[$urandom_range(0, 3)] : SLOT_W'($urandom);
      key_pool[j] = {KEY_HI_W'($urandom), home};
      if (key_pool[j] == '0) key_pool[j][KEY_W-1] = 1'b1;
    end
    phase_kind = '{KIND_QUAD, KIND_DOUBLE, KIND_LINEAR, KIND_UNUSED, KIND_DOUBLE, KIND_QUAD};
    phase_mix = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_BALANCED, MIX_FILL};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, rejected keys, overwrite, tombstones, wrap-around
    send(MODE_FIND, 32'd5, 32'h1111_1111);
    send(MODE_REMOVE, 32'd5, '0);
    send(MODE_INSERT, '0, 32'hDEAD_BEEF);
    send(MODE_UNUSED, '0, '0);
    send(MODE_UNUSED, 32'd7, '1);
    send(MODE_INSERT, '1, '1);
    send(MODE_FIND, '1, '0);
    send(MODE_INSERT, '1, '0);
    send(MODE_FIND, '1, '1);
    send(MODE_INSERT, 32'd1, 32'h1234_5678);
    send(MODE_INSERT, 32'd65, 32'hA5A5_A5A5);
    send(MODE_INSERT, 32'd129, 32'h5A5A_5A5A);
    send(MODE_REMOVE, 32'd65, '0);
    send(MODE_FIND, 32'd129, '0);
    send(MODE_FIND, 32'd65, '0);
    send(MODE_INSERT, 32'd193, 32'h0F0F_0F0F);
    send(MODE_REMOVE, 32'd65, '0);
    send(MODE_FIND, '0, '0);
    send(MODE_REMOVE, '0, '0);
    send(MODE_INSERT, 32'd63, 32'h8000_0001);
    send(MODE_FIND, 32'd63, '0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(ADDR_PROBE_KIND, PDATA_W'(phase_kind[p]));
      for (int n = 0; n < PHASE_ITEMS; n++) send(pick_mode(phase_mix[p]), pick_key(), pick_value());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    done <= 1'b1;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard: far beyond every item probing the whole table under heavy stall
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
